FILE: rtl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types, codes and the clip plane table of the frustum cube cull block.
// ----------------------------------------------------------------------------
package fcc_pkg;

    // Request operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // Matrix geometry: element index is column*4+row
    localparam int ELEM_W     = 32;
    localparam int IDX_W      = 4;
    localparam int HALF_W     = 31;
    localparam int COEF_W     = ELEM_W + 1;   // sum of two elements
    localparam int CORNER_W   = ELEM_W + 1;   // centre plus or minus half size
    localparam int PROD_W     = COEF_W + CORNER_W;
    localparam int ACC_W      = PROD_W + 2;   // sum of four terms
    localparam int PLANE_IDX_W = 3;
    localparam int MAX_PLANES = 6;

    // Column codes: three axis columns and the constant column
    localparam logic [1:0] COL_X = 2'd0;
    localparam logic [1:0] COL_Y = 2'd1;
    localparam logic [1:0] COL_Z = 2'd2;
    localparam logic [1:0] COL_D = 2'd3;

    // Row added to every plane but near
    localparam logic [1:0] ROW_W = 2'd3;

    // Constant term is scaled by one in Q16.16
    localparam logic signed [CORNER_W-1:0] D_SCALE = CORNER_W'(65536);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // Per plane recipe: which row, whether row 3 is added, whether row is negated
    typedef struct packed {
        logic [1:0] row;
        logic       use_w;
        logic       neg;
    } t_plane_cfg;

    // One column fetch issued by the sequencer
    typedef struct packed {
        logic       valid;
        logic [1:0] col;
        logic [1:0] row;
        logic       use_w;
        logic       neg;
    } t_issue;

    // Plane outcome reported by the dot product unit
    typedef struct packed {
        logic done;
        logic cull;
    } t_plane_res;

    function automatic t_plane_cfg plane_cfg(input logic [PLANE_IDX_W-1:0] idx);
        t_plane_cfg cfg;
        cfg = '0;
        unique case (idx)
            3'd0:    cfg = '{row: 2'd0, use_w: 1'b1, neg: 1'b1};  // right
            3'd1:    cfg = '{row: 2'd0, use_w: 1'b1, neg: 1'b0};  // left
            3'd2:    cfg = '{row: 2'd1, use_w: 1'b1, neg: 1'b0};  // bottom
            3'd3:    cfg = '{row: 2'd1, use_w: 1'b1, neg: 1'b1};  // top
            3'd4:    cfg = '{row: 2'd2, use_w: 1'b1, neg: 1'b1};  // far
            3'd5:    cfg = '{row: 2'd2, use_w: 1'b0, neg: 1'b0};  // near
            default: cfg = '0;
        endcase
        return cfg;
    endfunction

endpackage

FILE: rtl/fcc_mat_mem.sv
// ----------------------------------------------------------------------------
// fcc_mat_mem
// 16 x 32 matrix store, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module fcc_mat_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [fcc_pkg::IDX_W-1:0]     i_waddr,
    input  logic [fcc_pkg::ELEM_W-1:0]    i_wdata,
    input  logic [fcc_pkg::IDX_W-1:0]     i_raddr_a,
    input  logic [fcc_pkg::IDX_W-1:0]     i_raddr_b,
    output logic [fcc_pkg::ELEM_W-1:0]    o_rdata_a,
    output logic [fcc_pkg::ELEM_W-1:0]    o_rdata_b
);
    import fcc_pkg::*;

    localparam int DEPTH = 1 << IDX_W;

    logic [ELEM_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [ELEM_W-1:0] r_rd_a;
    logic [ELEM_W-1:0] r_rd_b;

    // Track written entries; unwritten ones read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_valid[i_raddr_a] ? r_mem[i_raddr_a] : '0;
        r_rd_b <= r_valid[i_raddr_b] ? r_mem[i_raddr_b] : '0;
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

FILE: rtl/fcc_dot_unit.sv
// ----------------------------------------------------------------------------
// fcc_dot_unit
// Shared multiply-accumulate pipeline: builds one plane coefficient per cycle,
// multiplies it by the farthest cube corner or by one, and sums the plane.
// ----------------------------------------------------------------------------
module fcc_dot_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic signed [fcc_pkg::ELEM_W-1:0] i_cube_x,
    input  logic signed [fcc_pkg::ELEM_W-1:0] i_cube_y,
    input  logic signed [fcc_pkg::ELEM_W-1:0] i_cube_z,
    input  logic [fcc_pkg::HALF_W-1:0]     i_half_size,
    input  fcc_pkg::t_issue                i_issue,
    input  logic                           i_flush,
    input  logic [fcc_pkg::ELEM_W-1:0]     i_elem_a,
    input  logic [fcc_pkg::ELEM_W-1:0]     i_elem_b,
    output fcc_pkg::t_plane_res            o_res
);
    import fcc_pkg::*;

    logic signed [CORNER_W-1:0] r_lo [3];
    logic signed [CORNER_W-1:0] r_hi [3];
    logic signed [CORNER_W-1:0] ext_c [3];
    logic signed [CORNER_W-1:0] ext_h;

    logic                     r_s1_valid;
    logic [1:0]               r_s1_col;
    logic                     r_s1_neg;
    logic                     r_s1_use_w;

    logic                     r_s2_valid;
    logic [1:0]               r_s2_col;
    logic signed [COEF_W-1:0] r_coef;
    logic signed [COEF_W-1:0] n_coef;

    logic                     r_s3_valid;
    logic [1:0]               r_s3_col;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [CORNER_W-1:0] mul_op;

    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  prod_ext;

    // Cube corners on both sides of the centre, per axis
    always_comb begin
        ext_c[0] = {i_cube_x[ELEM_W-1], i_cube_x};
        ext_c[1] = {i_cube_y[ELEM_W-1], i_cube_y};
        ext_c[2] = {i_cube_z[ELEM_W-1], i_cube_z};
        ext_h    = {2'b00, i_half_size};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= ext_c[k] - ext_h;
                r_hi[k] <= ext_c[k] + ext_h;
            end
        end
    end

    // Stage valids: drop everything in flight on flush
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_issue.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Coefficient: plus or minus the plane row, plus row 3 when used
    always_comb begin
        logic signed [COEF_W-1:0] va;
        logic signed [COEF_W-1:0] vb;
        va = {i_elem_a[ELEM_W-1], i_elem_a};
        vb = r_s1_use_w ? {i_elem_b[ELEM_W-1], i_elem_b} : '0;
        n_coef = (r_s1_neg ? -va : va) + vb;
    end

    // Farthest corner along the plane normal: high side for a non-negative term
    always_comb begin
        mul_op = D_SCALE;
        unique case (r_s2_col)
            COL_X: mul_op = r_coef[COEF_W-1] ? r_lo[0] : r_hi[0];
            COL_Y: mul_op = r_coef[COEF_W-1] ? r_lo[1] : r_hi[1];
            COL_Z: mul_op = r_coef[COEF_W-1] ? r_lo[2] : r_hi[2];
            COL_D: mul_op = D_SCALE;
            default: mul_op = D_SCALE;
        endcase
        n_prod = r_coef * mul_op;
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        r_s1_col   <= i_issue.col;
        r_s1_neg   <= i_issue.neg;
        r_s1_use_w <= i_issue.use_w;
        r_s2_col   <= r_s1_col;
        r_coef     <= n_coef;
        r_s3_col   <= r_s2_col;
        r_prod     <= n_prod;
    end

    // Accumulate one plane, restarting on its first column
    always_comb begin
        prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        n_acc    = (r_s3_col == COL_X) ? prod_ext : r_acc + prod_ext;
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_res.done = r_s3_valid && (r_s3_col == COL_D);
    assign o_res.cull = n_acc[ACC_W-1];

endmodule

FILE: rtl/fcc_seq.sv
// ----------------------------------------------------------------------------
// fcc_seq
// Sequencer: walks planes and columns through the dot product unit, stops on
// the first culling plane and holds the result in the output register.
// ----------------------------------------------------------------------------
module fcc_seq #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  fcc_pkg::t_plane_res   i_res,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output fcc_pkg::t_issue       o_issue,
    output logic                  o_flush,
    output logic                  o_out_valid,
    output logic                  o_visible
);
    import fcc_pkg::*;

    localparam logic [PLANE_IDX_W-1:0] LAST_PLANE = PLANE_IDX_W'(PLANE_COUNT - 1);

    t_state                 r_state;
    t_state                 n_state;
    logic [PLANE_IDX_W-1:0] r_plane;
    logic [1:0]             r_col;
    logic                   r_issuing;
    logic [PLANE_IDX_W-1:0] r_done_cnt;
    logic                   r_vis_pend;
    logic                   r_out_valid;
    logic                   r_visible;
    logic                   finish;
    logic                   slot_free;
    t_plane_cfg             cfg;

    assign finish    = i_res.done && (i_res.cull || (r_done_cnt == LAST_PLANE));
    assign slot_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = ST_RUN;
            ST_RUN:  if (finish) n_state = ST_DONE;
            ST_DONE: if (slot_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Outputs
    always_comb begin
        cfg           = plane_cfg(r_plane);
        o_in_ready    = 1'b0;
        o_flush       = 1'b0;
        o_issue       = '0;
        o_issue.col   = r_col;
        o_issue.row   = cfg.row;
        o_issue.use_w = cfg.use_w;
        o_issue.neg   = cfg.neg;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_RUN: begin
                o_issue.valid = r_issuing;
                o_flush       = finish;
            end
            ST_DONE: o_flush = 1'b0;
            default: o_in_ready = 1'b0;
        endcase
    end

    // Advance plane and column counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing  <= 1'b0;
            r_plane    <= '0;
            r_col      <= COL_X;
            r_done_cnt <= '0;
        end else if (r_state == ST_IDLE && i_start) begin
            r_issuing  <= 1'b1;
            r_plane    <= '0;
            r_col      <= COL_X;
            r_done_cnt <= '0;
        end else if (r_state == ST_RUN) begin
            if (r_issuing) begin
                r_col <= r_col + 2'd1;
                if (r_col == COL_D) begin
                    if (r_plane == LAST_PLANE) begin
                        r_issuing <= 1'b0;
                    end else begin
                        r_plane <= r_plane + 1'b1;
                    end
                end
            end
            if (i_res.done) begin
                r_done_cnt <= r_done_cnt + 1'b1;
            end
        end
    end

    // Hold the outcome until the output register is free
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && finish) begin
            r_vis_pend <= !i_res.cull;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && slot_free) begin
            r_visible <= r_vis_pend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_visible   = r_visible;

endmodule

FILE: rtl/frustum_cube_cull.sv
// ----------------------------------------------------------------------------
// frustum_cube_cull
// View frustum test of an axis-aligned cube against six clip planes taken
// from a stored 4x4 view-projection matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries two kinds of request.
//   A load request (i_op = 0) writes i_element_value at i_element_index
//   (column*4+row) and yields no result.
//   A test request (i_op = 1) checks the cube given by its centre and half
//   size and yields one result on the output channel (o_out_valid /
//   i_out_ready): o_visible = 0 when one plane has the whole cube outside.
//   A test is worked through one shared multiply-accumulate unit, one plane
//   column per cycle, four columns a plane, and ends early when an early plane
//   culls. o_in_ready is low while a test is in progress and rises with the
//   result, so the next request can be taken in the same cycle as the result.
//   The result sits in an output register; a new request is taken while it
//   waits. A stalled receiver holds the block after its next test finishes.
//   Reset clears the matrix to zero, empties the output and leaves the block
//   ready.
// ----------------------------------------------------------------------------
module frustum_cube_cull #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [fcc_pkg::IDX_W-1:0]         i_element_index,
    input  logic signed [fcc_pkg::ELEM_W-1:0] i_element_value,
    input  logic signed [fcc_pkg::ELEM_W-1:0] i_cube_x,
    input  logic signed [fcc_pkg::ELEM_W-1:0] i_cube_y,
    input  logic signed [fcc_pkg::ELEM_W-1:0] i_cube_z,
    input  logic [fcc_pkg::HALF_W-1:0]        i_half_size,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_visible
);
    import fcc_pkg::*;

    logic              in_accept;
    logic              load_req;
    logic              test_req;
    t_issue            issue;
    t_plane_res        res;
    logic              flush;
    logic [ELEM_W-1:0] elem_a;
    logic [ELEM_W-1:0] elem_b;

    // Decode accepted request
    assign in_accept = i_in_valid && o_in_ready;
    assign load_req  = in_accept && (i_op == OP_LOAD);
    assign test_req  = in_accept && (i_op == OP_TEST);

    fcc_mat_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (load_req),
        .i_waddr   (i_element_index),
        .i_wdata   (i_element_value),
        .i_raddr_a ({issue.col, issue.row}),
        .i_raddr_b ({issue.col, ROW_W}),
        .o_rdata_a (elem_a),
        .o_rdata_b (elem_b)
    );

    fcc_dot_unit u_dot (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (test_req),
        .i_cube_x    (i_cube_x),
        .i_cube_y    (i_cube_y),
        .i_cube_z    (i_cube_z),
        .i_half_size (i_half_size),
        .i_issue     (issue),
        .i_flush     (flush),
        .i_elem_a    (elem_a),
        .i_elem_b    (elem_b),
        .o_res       (res)
    );

    fcc_seq #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (test_req),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_issue     (issue),
        .o_flush     (flush),
        .o_out_valid (o_out_valid),
        .o_visible   (o_visible)
    );

endmodule

FILE: rtl/fcc_checker.sv
// ----------------------------------------------------------------------------
// fcc_checker
// Port-level checks of the frustum cube cull block, bound to its top level.
// ----------------------------------------------------------------------------
module fcc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic i_op,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_visible
);

    // Reset empties the output and leaves the block ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");

    // A test request holds off the next request
    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_op) |=> !o_in_ready)
        else $error("request taken while a test is in progress");

    // A load request completes at once
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_op) |=> o_in_ready)
        else $error("load request left the block busy");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_visible)))
        else $error("stalled result dropped or changed");

endmodule

bind frustum_cube_cull fcc_checker u_fcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_op        (i_op),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_visible   (o_visible)
);
